// ===== rtl/rce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types, codes and helpers of the relay circuit rule evaluator.
// ----------------------------------------------------------------------------
package rce_pkg;

  // Default table depth and field widths
  localparam int unsigned DEF_DEPTH = 256;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RULE_W    = 2 * DATA_W;
  // Wide enough for any effective count up to the largest table depth
  localparam int unsigned EFF_W     = 13;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_WR_PREP  = 3'd0,
    OP_WR_MAIN  = 3'd1,
    OP_WR_STAT  = 3'd2,
    OP_WR_DYN   = 3'd3,
    OP_SET_BIT  = 3'd4,
    OP_CLR_BIT  = 3'd5,
    OP_CORRECT  = 3'd6,
    OP_RECALC   = 3'd7
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREP_COUNT = 3'd0,
    REG_MAIN_COUNT = 3'd1,
    REG_STAT_COUNT = 3'd2,
    REG_DYN_COUNT  = 3'd3,
    REG_BASE_MASK  = 3'd4
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Table being scanned
  typedef enum logic [1:0] {
    PH_PREP = 2'd0,
    PH_MAIN = 2'd1,
    PH_STAT = 2'd2,
    PH_DYN  = 2'd3
  } phase_t;

  // Round a count up to a multiple of four, then limit it to the depth
  function automatic logic [EFF_W-1:0] eff_count(input logic [CNT_W-1:0] cnt,
                                                 input logic [EFF_W-1:0] depth);
    logic [EFF_W-1:0] r;
    r = (EFF_W'(cnt) + EFF_W'(3)) & ~EFF_W'(3);
    return (r > depth) ? depth : r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rce_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rce_if
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rce_item_if;
  logic                             valid;
  logic                             ready;
  logic [rce_pkg::OP_W-1:0]         opcode;
  logic [rce_pkg::IDX_W-1:0]        table_index;
  logic [rce_pkg::DATA_W-1:0]       entry_mask;
  logic [rce_pkg::DATA_W-1:0]       entry_result;
  logic [rce_pkg::BIT_W-1:0]        status_bit;
  logic [rce_pkg::DATA_W-1:0]       set_bits;
  logic [rce_pkg::DATA_W-1:0]       keep_bits;

  modport source (output valid, opcode, table_index, entry_mask, entry_result,
                  status_bit, set_bits, keep_bits, input ready);
  modport sink   (input valid, opcode, table_index, entry_mask, entry_result,
                  status_bit, set_bits, keep_bits, output ready);
endinterface

interface rce_result_if;
  logic                             valid;
  logic                             ready;
  logic [rce_pkg::DATA_W-1:0]       main_output;
  logic [rce_pkg::DATA_W-1:0]       sensitive_output;
  logic                             recalc_pending;
  logic                             output_valid;

  modport source (output valid, main_output, sensitive_output, recalc_pending,
                  output_valid, input ready);
  modport sink   (input valid, main_output, sensitive_output, recalc_pending,
                  output_valid, output ready);
endinterface

interface rce_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rce_pkg::CFG_IDX_W-1:0]    index;
  logic [rce_pkg::DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rce_rule_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rce_rule_ram
// One rule table: single write port, single registered read port.
// ----------------------------------------------------------------------------
module rce_rule_ram #(
  parameter int unsigned DEPTH = rce_pkg::DEF_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire                            clk,
  input  wire                            wr_en,
  input  wire  [AW-1:0]                  wr_addr,
  input  wire  [rce_pkg::RULE_W-1:0]     wr_data,
  input  wire                            rd_en,
  input  wire  [AW-1:0]                  rd_addr,
  output logic [rce_pkg::RULE_W-1:0]     rd_data
);

  logic [rce_pkg::RULE_W-1:0] mem [DEPTH];

  // Write one rule
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one rule, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rce_match_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rce_match_unit
// Shared rule compare: tests mask against status, whole word or per half.
// ----------------------------------------------------------------------------
module rce_match_unit (
  input  wire  [rce_pkg::DATA_W-1:0] rule_mask,
  input  wire  [rce_pkg::DATA_W-1:0] rule_res,
  input  wire  [rce_pkg::DATA_W-1:0] status,
  input  wire                        halves,
  output logic [rce_pkg::DATA_W-1:0] contrib
);

  localparam int unsigned HW = rce_pkg::DATA_W / 2;

  logic [rce_pkg::DATA_W-1:0] miss;
  logic                       lo_hit;
  logic                       hi_hit;

  // Missing bits decide the hit, per half or for the whole word
  always_comb begin
    miss   = rule_mask & ~status;
    lo_hit = (miss[HW-1:0] == '0);
    hi_hit = (miss[rce_pkg::DATA_W-1:HW] == '0);
    if (halves) begin
      contrib = {hi_hit ? rule_res[rce_pkg::DATA_W-1:HW] : {HW{1'b0}},
                 lo_hit ? rule_res[HW-1:0] : {HW{1'b0}}};
    end else begin
      contrib = (lo_hit && hi_hit) ? rule_res : '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/relay_circuit_rule_evaluator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Set, clear, correct and rule writes give their result in the cycle after the request is taken.
// Recalculate: scans the prepare, main, static and dynamic tables in order, each up to its
// effective rule count; one shared compare unit takes one rule per cycle.
// Throughput: one simple request per cycle while each result is taken; none during a recalculate.
// Reset: synchronous; then a clearing pass over the largest table depth (256 by default)
// zeroes all four tables, and no request is taken until it ends.
// ----------------------------------------------------------------------------
// relay_circuit_rule_evaluator_core
// Status word, four rule tables and a sequencer that scans them through one
// compare unit to form the main and sensitive words.
// ----------------------------------------------------------------------------
module relay_circuit_rule_evaluator_core #(
  parameter int unsigned PREPARE_DEPTH = rce_pkg::DEF_DEPTH,
  parameter int unsigned MAIN_DEPTH    = rce_pkg::DEF_DEPTH,
  parameter int unsigned STATIC_DEPTH  = rce_pkg::DEF_DEPTH,
  parameter int unsigned DYNAMIC_DEPTH = rce_pkg::DEF_DEPTH
) (
  input  wire          clk,
  input  wire          rst,
  rce_item_if.sink     item,
  rce_result_if.source result,
  rce_cfg_if.sink      cfg
);

  localparam int unsigned TAB_DEPTH [4] = '{PREPARE_DEPTH, MAIN_DEPTH,
                                           STATIC_DEPTH, DYNAMIC_DEPTH};
  localparam int unsigned MAX_PM = (PREPARE_DEPTH > MAIN_DEPTH) ? PREPARE_DEPTH : MAIN_DEPTH;
  localparam int unsigned MAX_SD = (STATIC_DEPTH > DYNAMIC_DEPTH) ? STATIC_DEPTH : DYNAMIC_DEPTH;
  localparam int unsigned MAXD   = (MAX_PM > MAX_SD) ? MAX_PM : MAX_SD;
  localparam int unsigned CLRW   = $clog2(MAXD);
  localparam int unsigned CW     = $clog2(MAXD + 1);
  localparam int unsigned IXW    = (CW > rce_pkg::IDX_W) ? CW : rce_pkg::IDX_W;
  localparam rce_pkg::op_t TAB_OP [4] = '{rce_pkg::OP_WR_PREP, rce_pkg::OP_WR_MAIN,
                                          rce_pkg::OP_WR_STAT, rce_pkg::OP_WR_DYN};

  // Sequencer
  rce_pkg::state_t  state;
  rce_pkg::state_t  state_next;
  rce_pkg::phase_t  phase;
  rce_pkg::phase_t  phase_next;
  logic [CW-1:0]    scan_addr;
  logic [CW-1:0]    scan_addr_next;
  logic [CLRW-1:0]  clr_addr;
  logic [CLRW-1:0]  clr_addr_next;
  logic [CW-1:0]    scan_limit;
  logic             issue;
  logic             finish;

  // Block state and configuration
  logic [CW-1:0]               eff [4];
  logic [rce_pkg::DATA_W-1:0]  base_mask;
  logic [rce_pkg::DATA_W-1:0]  status_word;
  logic [rce_pkg::DATA_W-1:0]  status_next;
  logic                        pending;
  logic                        pending_next;
  logic [rce_pkg::DATA_W-1:0]  sensitive_word;

  // Scan datapath
  logic                        rd_valid;
  rce_pkg::phase_t             rd_phase;
  logic [rce_pkg::RULE_W-1:0]  rd_data [4];
  logic [rce_pkg::RULE_W-1:0]  rd_rule;
  logic [rce_pkg::DATA_W-1:0]  work;
  logic [rce_pkg::DATA_W-1:0]  main_acc;
  logic [rce_pkg::DATA_W-1:0]  sens_acc;
  logic [rce_pkg::DATA_W-1:0]  cmp_status;
  logic                        cmp_halves;
  logic [rce_pkg::DATA_W-1:0]  contrib;

  // Output register
  logic                        ov;
  logic [rce_pkg::DATA_W-1:0]  o_main;
  logic [rce_pkg::DATA_W-1:0]  o_sens;
  logic                        o_pend;
  logic                        o_valid;

  // Handshake
  rce_pkg::op_t op;
  logic         slot_free;
  logic         item_acc;
  logic         simple_acc;
  logic         load;

  assign op          = rce_pkg::op_t'(item.opcode);
  assign slot_free   = !ov || result.ready;
  assign item.ready  = (state == rce_pkg::ST_IDLE) && slot_free;
  assign item_acc    = item.valid && item.ready;
  assign simple_acc  = item_acc && (op != rce_pkg::OP_RECALC);
  assign load        = simple_acc || finish;
  assign cfg.ready   = 1'b1;
  assign scan_limit  = eff[phase];

  // Rule tables: clearing pass after reset, else rule writes within the count
  for (genvar g = 0; g < 4; g++) begin : g_tab
    localparam int unsigned AW = $clog2(TAB_DEPTH[g]);
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [rce_pkg::RULE_W-1:0]  wr_data;
    logic                        clr_hit;
    logic                        wr_hit;

    always_comb begin
      clr_hit = (state == rce_pkg::ST_CLEAR) && (CW'(clr_addr) < CW'(TAB_DEPTH[g]));
      wr_hit  = item_acc && (op == TAB_OP[g]) &&
                (IXW'(item.table_index) < IXW'(eff[g]));
      wr_en   = clr_hit || wr_hit;
      wr_addr = clr_hit ? AW'(clr_addr) : AW'(item.table_index);
      wr_data = clr_hit ? '0 : {item.entry_mask, item.entry_result};
    end

    rce_rule_ram #(
      .DEPTH (TAB_DEPTH[g])
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue && (phase == rce_pkg::phase_t'(g))),
      .rd_addr (AW'(scan_addr)),
      .rd_data (rd_data[g])
    );
  end

  // Shared compare: prepare rules test live status, the rest the working copy
  assign rd_rule    = rd_data[rd_phase];
  assign cmp_status = (rd_phase == rce_pkg::PH_PREP) ? status_word : work;
  assign cmp_halves = (rd_phase == rce_pkg::PH_STAT) || (rd_phase == rce_pkg::PH_DYN);

  rce_match_unit u_match (
    .rule_mask (rd_rule[rce_pkg::RULE_W-1:rce_pkg::DATA_W]),
    .rule_res  (rd_rule[rce_pkg::DATA_W-1:0]),
    .status    (cmp_status),
    .halves    (cmp_halves),
    .contrib   (contrib)
  );

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rce_pkg::ST_CLEAR;
      phase     <= rce_pkg::PH_PREP;
      scan_addr <= '0;
      clr_addr  <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      scan_addr <= scan_addr_next;
      clr_addr  <= clr_addr_next;
    end
  end

  // Advance clear sweep, table scan and result hand-off
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    scan_addr_next = scan_addr;
    clr_addr_next  = clr_addr;
    issue          = 1'b0;
    finish         = 1'b0;
    case (state)
      rce_pkg::ST_CLEAR: begin
        clr_addr_next = clr_addr + CLRW'(1);
        if (clr_addr == CLRW'(MAXD - 1)) begin
          state_next = rce_pkg::ST_IDLE;
        end
      end
      rce_pkg::ST_IDLE: begin
        if (item_acc && (op == rce_pkg::OP_RECALC)) begin
          state_next     = rce_pkg::ST_SCAN;
          phase_next     = rce_pkg::PH_PREP;
          scan_addr_next = '0;
        end
      end
      rce_pkg::ST_SCAN: begin
        if (scan_addr < scan_limit) begin
          issue          = 1'b1;
          scan_addr_next = scan_addr + CW'(1);
        end else begin
          scan_addr_next = '0;
          case (phase)
            rce_pkg::PH_PREP: phase_next = rce_pkg::PH_MAIN;
            rce_pkg::PH_MAIN: phase_next = rce_pkg::PH_STAT;
            rce_pkg::PH_STAT: phase_next = rce_pkg::PH_DYN;
            default:          state_next = rce_pkg::ST_DONE;
          endcase
        end
      end
      rce_pkg::ST_DONE: begin
        if (slot_free) begin
          finish     = 1'b1;
          state_next = rce_pkg::ST_IDLE;
        end
      end
      default: state_next = rce_pkg::ST_IDLE;
    endcase
  end

  // Take configuration writes; counts are stored already rounded and limited
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        eff[i] <= '0;
      end
      base_mask <= '0;
    end else if (cfg.valid) begin
      case (rce_pkg::reg_idx_t'(cfg.index))
        rce_pkg::REG_PREP_COUNT: eff[0] <= CW'(rce_pkg::eff_count(
            cfg.data[rce_pkg::CNT_W-1:0], rce_pkg::EFF_W'(TAB_DEPTH[0])));
        rce_pkg::REG_MAIN_COUNT: eff[1] <= CW'(rce_pkg::eff_count(
            cfg.data[rce_pkg::CNT_W-1:0], rce_pkg::EFF_W'(TAB_DEPTH[1])));
        rce_pkg::REG_STAT_COUNT: eff[2] <= CW'(rce_pkg::eff_count(
            cfg.data[rce_pkg::CNT_W-1:0], rce_pkg::EFF_W'(TAB_DEPTH[2])));
        rce_pkg::REG_DYN_COUNT:  eff[3] <= CW'(rce_pkg::eff_count(
            cfg.data[rce_pkg::CNT_W-1:0], rce_pkg::EFF_W'(TAB_DEPTH[3])));
        rce_pkg::REG_BASE_MASK:  base_mask <= cfg.data;
        default: ;
      endcase
    end
  end

  // Status update of set, clear and correct
  always_comb begin
    case (op)
      rce_pkg::OP_SET_BIT: status_next = status_word | (32'd1 << item.status_bit);
      rce_pkg::OP_CLR_BIT: status_next = status_word & ~(32'd1 << item.status_bit);
      rce_pkg::OP_CORRECT: status_next = item.set_bits | (status_word & item.keep_bits);
      default:             status_next = status_word;
    endcase
    pending_next = pending || (status_next != status_word);
  end

  // Hold status, pending flag and sensitive word
  always_ff @(posedge clk) begin
    if (rst) begin
      status_word    <= '0;
      pending        <= 1'b0;
      sensitive_word <= '0;
    end else if (simple_acc) begin
      status_word <= status_next;
      pending     <= pending_next;
    end else if (finish) begin
      pending        <= 1'b0;
      sensitive_word <= base_mask | sens_acc;
    end
  end

  // Track read data in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_phase <= rce_pkg::PH_PREP;
    end else begin
      rd_valid <= issue;
      rd_phase <= phase;
    end
  end

  // Accumulate matching rule results per stage
  always_ff @(posedge clk) begin
    if (item_acc && (op == rce_pkg::OP_RECALC)) begin
      work     <= status_word;
      main_acc <= '0;
      sens_acc <= '0;
    end else if (rd_valid) begin
      case (rd_phase)
        rce_pkg::PH_PREP: work     <= work | contrib;
        rce_pkg::PH_MAIN: main_acc <= main_acc | contrib;
        default:          sens_acc <= sens_acc | contrib;
      endcase
    end
  end

  // Output register: load one result per request, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (simple_acc) begin
      o_main  <= '0;
      o_sens  <= sensitive_word;
      o_pend  <= pending_next;
      o_valid <= 1'b0;
    end else if (finish) begin
      o_main  <= main_acc;
      o_sens  <= base_mask | sens_acc;
      o_pend  <= 1'b0;
      o_valid <= 1'b1;
    end
  end

  assign result.valid            = ov;
  assign result.main_output      = o_main;
  assign result.sensitive_output = o_sens;
  assign result.recalc_pending   = o_pend;
  assign result.output_valid     = o_valid;

`ifndef NO_ASSERTIONS
  // Read data only follows a scan cycle
  a_rd_after_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ($past(state) == rce_pkg::ST_SCAN))
    else $error("rule read data without a scan cycle");

  // Scan address never runs past the table's effective count
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rce_pkg::ST_SCAN) |-> (scan_addr <= scan_limit))
    else $error("scan address beyond effective count");

  // Finishing a recalculate leaves a valid result with pending cleared
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> (ov && o_valid && !o_pend && !pending && (state == rce_pkg::ST_IDLE)))
    else $error("recalculate result not loaded");

  // Only recalculate changes the sensitive word
  a_sens_stable: assert property (@(posedge clk) disable iff (rst)
    simple_acc |=> $stable(sensitive_word))
    else $error("sensitive word changed by a simple request");
`endif

endmodule
`default_nettype wire

// ===== dv/rule_eval_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rule_eval_checker
// Monitors the request, result and register channels of the relay circuit
// rule evaluator. Keeps its own status word, rule tables and register copy,
// predicts the result of every accepted request and compares each accepted
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rule_eval_checker (
  input  logic        clk,
  input  logic        rst,
  rce_item_if         item_mon,
  rce_result_if       result_mon,
  rce_cfg_if          cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned awaiting_count
);
  import rce_pkg::*;

  localparam int unsigned       TABLE_DEPTH = DEF_DEPTH;
  localparam logic [DATA_W-1:0] LOW_HALF    = 32'h0000_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] res;
  } rule_t;

  typedef struct packed {
    logic [DATA_W-1:0] main_word;
    logic [DATA_W-1:0] sens_word;
    logic              pending;
    logic              fresh;
  } reply_t;

  rule_t             rule_tbl [4][TABLE_DEPTH];
  logic [CNT_W-1:0]  rule_cnt [4];
  logic [DATA_W-1:0] base_mask;
  logic [DATA_W-1:0] status_q;
  logic [DATA_W-1:0] sensitive_q;
  logic              pending_q;
  reply_t            predicted_outputs [$];

  // Round the count up to a multiple of four, then clip to the depth
  function automatic int unsigned rules_in_use(input phase_t tbl);
    int unsigned rounded;
    rounded = (32'(rule_cnt[tbl]) + 32'd3) & 32'hFFFF_FFFC;
    return (rounded > TABLE_DEPTH) ? TABLE_DEPTH : rounded;
  endfunction

  // OR the results of rules whose mask bits are all present in word
  function automatic logic [DATA_W-1:0] scan_full(input phase_t tbl,
                                                  input logic [DATA_W-1:0] word);
    logic [DATA_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < int'(rules_in_use(tbl)); i++) begin
      if ((rule_tbl[tbl][i].mask & ~word) == '0) acc |= rule_tbl[tbl][i].res;
    end
    return acc;
  endfunction

  // Same match, done on each 16-bit half on its own
  function automatic logic [DATA_W-1:0] scan_halves(input phase_t tbl,
                                                    input logic [DATA_W-1:0] word);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] miss;
    acc = '0;
    for (int i = 0; i < int'(rules_in_use(tbl)); i++) begin
      miss = rule_tbl[tbl][i].mask & ~word;
      if ((miss & LOW_HALF) == '0) acc |= rule_tbl[tbl][i].res & LOW_HALF;
      if ((miss & ~LOW_HALF) == '0) acc |= rule_tbl[tbl][i].res & ~LOW_HALF;
    end
    return acc;
  endfunction

  // Drop writes to slots past the effective count
  function automatic void store_rule(input phase_t tbl, input logic [IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] mask,
                                     input logic [DATA_W-1:0] res);
    if (idx < rules_in_use(tbl)) rule_tbl[tbl][idx] = '{mask, res};
  endfunction

  // Append one prediction at the tail of the queue
  function automatic void queue_reply(input reply_t rep);
    predicted_outputs = {predicted_outputs, rep};
  endfunction

  // Advance the predicted state by one request and return its result
  function automatic reply_t apply_request(input logic [OP_W-1:0]   op_bits,
                                           input logic [IDX_W-1:0]  idx,
                                           input logic [DATA_W-1:0] mask,
                                           input logic [DATA_W-1:0] res,
                                           input logic [BIT_W-1:0]  bit_no,
                                           input logic [DATA_W-1:0] set_w,
                                           input logic [DATA_W-1:0] keep_w);
    reply_t            o;
    logic [DATA_W-1:0] next_status;
    logic [DATA_W-1:0] work;
    logic              status_op;
    o           = '0;
    next_status = status_q;
    status_op   = 1'b0;
    case (op_t'(op_bits))
      OP_WR_PREP: store_rule(PH_PREP, idx, mask, res);
      OP_WR_MAIN: store_rule(PH_MAIN, idx, mask, res);
      OP_WR_STAT: store_rule(PH_STAT, idx, mask, res);
      OP_WR_DYN:  store_rule(PH_DYN, idx, mask, res);
      OP_SET_BIT: begin
        next_status = status_q | (32'd1 << bit_no);
        status_op   = 1'b1;
      end
      OP_CLR_BIT: begin
        next_status = status_q & ~(32'd1 << bit_no);
        status_op   = 1'b1;
      end
      OP_CORRECT: begin
        next_status = set_w | (status_q & keep_w);
        status_op   = 1'b1;
      end
      OP_RECALC: begin
        // prepare rules test the raw status, the rest test the widened copy
        work        = status_q | scan_full(PH_PREP, status_q);
        o.main_word = scan_full(PH_MAIN, work);
        sensitive_q = base_mask | scan_halves(PH_STAT, work) | scan_halves(PH_DYN, work);
        pending_q   = 1'b0;
        o.fresh     = 1'b1;
      end
    endcase
    // Raise pending only on a real change of status
    if (status_op) begin
      if (next_status != status_q) pending_q = 1'b1;
      status_q = next_status;
    end
    o.sens_word = sensitive_q;
    o.pending   = pending_q;
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    reply_t want;
    if (rst) begin
      for (int t = 0; t < 4; t++) begin
        rule_cnt[t] = '0;
        for (int i = 0; i < int'(TABLE_DEPTH); i++) rule_tbl[t][i] = '0;
      end
      base_mask      = '0;
      status_q       = '0;
      sensitive_q    = '0;
      pending_q      = 1'b0;
      mismatch_count = 0;
      predicted_outputs.delete();
    end else begin
      // Track register writes; unknown indexes are dropped
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_idx_t'(cfg_mon.index))
          REG_PREP_COUNT: rule_cnt[PH_PREP] = cfg_mon.data[CNT_W-1:0];
          REG_MAIN_COUNT: rule_cnt[PH_MAIN] = cfg_mon.data[CNT_W-1:0];
          REG_STAT_COUNT: rule_cnt[PH_STAT] = cfg_mon.data[CNT_W-1:0];
          REG_DYN_COUNT:  rule_cnt[PH_DYN]  = cfg_mon.data[CNT_W-1:0];
          REG_BASE_MASK:  base_mask         = cfg_mon.data;
          default: ;
        endcase
      end
      // Compare before pushing, so a same-edge request never pairs with its own result
      if (result_mon.valid && result_mon.ready) begin
        if (predicted_outputs.size() == 0) begin
          $error("result accepted with no request outstanding");
          mismatch_count++;
        end else begin
          want = predicted_outputs.pop_front();
          if (result_mon.main_output !== want.main_word) begin
            $error("main_output: expected %h, got %h", want.main_word,
                   result_mon.main_output);
            mismatch_count++;
          end
          if (result_mon.sensitive_output !== want.sens_word) begin
            $error("sensitive_output: expected %h, got %h", want.sens_word,
                   result_mon.sensitive_output);
            mismatch_count++;
          end
          if (result_mon.recalc_pending !== want.pending) begin
            $error("recalc_pending: expected %b, got %b", want.pending,
                   result_mon.recalc_pending);
            mismatch_count++;
          end
          if (result_mon.output_valid !== want.fresh) begin
            $error("output_valid: expected %b, got %b", want.fresh,
                   result_mon.output_valid);
            mismatch_count++;
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        queue_reply(apply_request(item_mon.opcode, item_mon.table_index,
                                  item_mon.entry_mask, item_mon.entry_result,
                                  item_mon.status_bit, item_mon.set_bits,
                                  item_mon.keep_bits));
      end
    end
    awaiting_count = predicted_outputs.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the relay circuit rule evaluator through a directed pass over rule
// slots, count rounding, status edits and recalculation, then random phases
// of rule loads, status edits and recalculates under fresh register settings.
// Requests come in bursts, the result side stalls on its own pattern, and a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import rce_pkg::*;

  localparam int unsigned RESET_CYCLES     = 8;
  localparam int unsigned QUIET_LIMIT      = 6000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 70;
  localparam int unsigned SETTLE_CYCLES    = 40;
  // Index past the register file; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam op_t WRITE_OPS [4]  = '{OP_WR_PREP, OP_WR_MAIN, OP_WR_STAT, OP_WR_DYN};
  localparam op_t STATUS_OPS [3] = '{OP_SET_BIT, OP_CLR_BIT, OP_CORRECT};

  typedef struct packed {
    op_t               opcode;
    logic [IDX_W-1:0]  table_index;
    logic [DATA_W-1:0] entry_mask;
    logic [DATA_W-1:0] entry_result;
    logic [BIT_W-1:0]  status_bit;
    logic [DATA_W-1:0] set_bits;
    logic [DATA_W-1:0] keep_bits;
  } request_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  int unsigned      burst_left = 0;
  bit               long_hold_req = 1'b0;
  logic [CNT_W-1:0] table_cnt [4];
  int unsigned      mismatch_count;
  int unsigned      awaiting_count;

  rce_item_if   item_ch ();
  rce_result_if result_ch ();
  rce_cfg_if    cfg_ch ();

  relay_circuit_rule_evaluator_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rule_eval_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_mon       (item_ch),
    .result_mon     (result_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_count (mismatch_count),
    .awaiting_count (awaiting_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one request; open a new burst after a random gap when the last one ends
  task automatic send_request(input request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      item_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    item_ch.valid        <= 1'b1;
    item_ch.opcode       <= r.opcode;
    item_ch.table_index  <= r.table_index;
    item_ch.entry_mask   <= r.entry_mask;
    item_ch.entry_result <= r.entry_result;
    item_ch.status_bit   <= r.status_bit;
    item_ch.set_bits     <= r.set_bits;
    item_ch.keep_bits    <= r.keep_bits;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off new requests until every outstanding result is back
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (awaiting_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all registers plus one unmapped index; only call while idle
  task automatic load_config(input logic [CNT_W-1:0] p, input logic [CNT_W-1:0] m,
                             input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] d,
                             input logic [DATA_W-1:0] base);
    logic [CFG_IDX_W-1:0] idx_list [6];
    logic [DATA_W-1:0]    val_list [6];
    idx_list = '{REG_PREP_COUNT, REG_MAIN_COUNT, REG_STAT_COUNT, REG_DYN_COUNT,
                 REG_BASE_MASK, REG_SPARE};
    val_list = '{32'(p), 32'(m), 32'(s), 32'(d), base, $urandom()};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx_list[i];
      cfg_ch.data  <= val_list[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
    table_cnt[PH_PREP] = p;
    table_cnt[PH_MAIN] = m;
    table_cnt[PH_STAT] = s;
    table_cnt[PH_DYN]  = d;
  endtask

  // Result side: ready runs and short stalls, plus one long hold on request
  initial begin : result_sink
    int unsigned run_len;
    int unsigned stall_len;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 10);
      result_ch.ready <= 1'b1;
      repeat (run_len) begin
        @(negedge clk);
        if (long_hold_req) break;
      end
      if (!long_hold_req) begin
        stall_len = $urandom_range(1, 4);
        result_ch.ready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  // End the run when no channel has moved for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("relay_circuit_rule_evaluator_core verification failed");
    $finish;
  end

  initial begin : stimulus
    request_t         r;
    logic [CNT_W-1:0] cnt_pick [4];
    logic [DATA_W-1:0] base_pick;
    int unsigned      pick;
    int unsigned      tbl;
    int unsigned      slots;

    item_ch.valid        = 1'b0;
    item_ch.opcode       = '0;
    item_ch.table_index  = '0;
    item_ch.entry_mask   = '0;
    item_ch.entry_result = '0;
    item_ch.status_bit   = '0;
    item_ch.set_bits     = '0;
    item_ch.keep_bits    = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Short tables with rounding slack; nonzero base mask
    load_config(9'd1, 9'd4, 9'd5, 9'd2, 32'hA5A5_0F0F);
    // prepare slot 3 is slack of a count of one; slot 4 is past it
    send_request('{OP_WR_PREP, 8'd3, 32'h0000_0001, 32'h0000_0100, '0, '0, '0});
    send_request('{OP_WR_PREP, 8'd4, '0, '1, '0, '0, '0});
    send_request('{OP_WR_MAIN, 8'd0, 32'h0000_0101, '1, '0, '0, '0});
    send_request('{OP_WR_MAIN, 8'd255, '0, 32'h0000_1234, '0, '0, '0});
    send_request('{OP_WR_STAT, 8'd7, 32'h0001_0001, '1, '0, '0, '0});
    send_request('{OP_WR_DYN, 8'd0, '1, '1, '0, '0, '0});
    send_request('{OP_WR_DYN, 8'd3, 32'h8000_0000, 32'hFFFF_0000, '0, '0, '0});
    send_request('{OP_RECALC, '0, '0, '0, '0, '0, '0});
    // Same bit twice: the second leaves status unchanged
    send_request('{OP_SET_BIT, '0, '0, '0, 5'd0, '0, '0});
    send_request('{OP_SET_BIT, '0, '0, '0, 5'd0, '0, '0});
    send_request('{OP_RECALC, '0, '0, '0, '0, '0, '0});
    send_request('{OP_SET_BIT, '0, '0, '0, 5'd31, '0, '0});
    send_request('{OP_CLR_BIT, '0, '0, '0, 5'd31, '0, '0});
    send_request('{OP_CLR_BIT, '0, '0, '0, 5'd5, '0, '0});
    send_request('{OP_CORRECT, '0, '0, '0, '0, '1, '0});
    send_request('{OP_RECALC, '0, '0, '0, '0, '0, '0});
    send_request('{OP_CORRECT, '0, '0, '0, '0, '0, '0});
    send_request('{OP_CORRECT, '0, '0, '0, '0, '0, '1});
    send_request('{OP_SET_BIT, '0, '0, '0, 5'd16, '0, '0});
    send_request('{OP_RECALC, '0, '0, '0, '0, '0, '0});
    drain();

    // Full tables, one count past the depth, all-ones base mask
    load_config(9'd256, 9'd511, 9'd253, 9'd256, '1);
    send_request('{OP_WR_PREP, 8'd255, 32'h0000_0080, 32'h0001_0000, '0, '0, '0});
    send_request('{OP_WR_MAIN, 8'd255, 32'h0001_0000, 32'hDEAD_BEEF, '0, '0, '0});
    send_request('{OP_WR_STAT, 8'd255, 32'h0000_0080, 32'h0F0F_F0F0, '0, '0, '0});
    send_request('{OP_WR_DYN, 8'd255, '1, '1, '0, '0, '0});
    send_request('{OP_SET_BIT, '0, '0, '0, 5'd7, '0, '0});
    send_request('{OP_RECALC, '0, '0, '0, '0, '0, '0});
    drain();

    // Empty tables: writes dropped, nothing scanned
    load_config('0, '0, '0, '0, '0);
    send_request('{OP_WR_PREP, 8'd0, '0, '1, '0, '0, '0});
    send_request('{OP_RECALC, '0, '0, '0, '0, '0, '0});

    for (int ph = 0; ph < int'(RANDOM_PHASES); ph++) begin
      drain();
      // Mostly short tables, now and then a full or oversized count
      for (int t = 0; t < 4; t++) begin
        cnt_pick[t] = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(0, 511))
                                                  : CNT_W'($urandom_range(0, 13));
      end
      case ($urandom_range(0, 3))
        0:       base_pick = '0;
        1:       base_pick = '1;
        default: base_pick = $urandom();
      endcase
      load_config(cnt_pick[0], cnt_pick[1], cnt_pick[2], cnt_pick[3], base_pick);

      for (int n = 0; n < int'(ITEMS_PER_PHASE); n++) begin
        if (ph == 1 && n == 10) long_hold_req = 1'b1;
        r.table_index  = IDX_W'($urandom_range(0, 255));
        r.entry_mask   = $urandom();
        r.entry_result = $urandom();
        r.status_bit   = BIT_W'($urandom_range(0, 31));
        r.set_bits     = $urandom();
        r.keep_bits    = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          // Rule load, mostly into live slots, with sparse masks so rules fire
          tbl      = $urandom_range(0, 3);
          r.opcode = WRITE_OPS[tbl];
          slots    = (32'(table_cnt[tbl]) + 32'd3) & 32'hFFFF_FFFC;
          if (slots > DEF_DEPTH) slots = DEF_DEPTH;
          if (slots != 0 && $urandom_range(0, 4) != 0) begin
            r.table_index = IDX_W'($urandom_range(0, slots - 1));
          end
          case ($urandom_range(0, 9))
            0:       r.entry_mask = '0;
            1:       r.entry_mask = '1;
            default: r.entry_mask = $urandom() & $urandom() & $urandom();
          endcase
        end else if (pick < 80) begin
          r.opcode = STATUS_OPS[$urandom_range(0, 2)];
          // A no-op correction now and then
          if ($urandom_range(0, 9) == 0) begin
            r.set_bits  = '0;
            r.keep_bits = '1;
          end
        end else begin
          r.opcode = OP_RECALC;
        end
        send_request(r);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && awaiting_count == 0) begin
      $display("relay_circuit_rule_evaluator_core verification clean");
    end else begin
      $display("relay_circuit_rule_evaluator_core verification failed");
    end
    $finish;
  end

endmodule
